@@ design/ngd_pkg.sv @@
`timescale 1ns / 1ps

package ngd_pkg;

  // Grid storage size.
  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int CELLS    = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W   = $clog2(CELLS);

  // Fixed field widths of the ports.
  localparam int FIELD_W  = 6;
  localparam int CFG_W    = 7;
  localparam int OUT_W    = 7;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  // Width that holds a count up to the larger grid side.
  localparam int CNT_W    = $clog2(((MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS) + 1);
  // Compare width that holds counts, register values and input coordinates.
  localparam int CMP_W    = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;

  // Internal distance width and the saturation width of the result.
  localparam int DIST_W     = $clog2(MAX_ROWS + MAX_COLS - 1);
  localparam int DIST_EXT_W = ((DIST_W > OUT_W) ? DIST_W : OUT_W) + 1;
  localparam int DIST_SAT   = (2 ** OUT_W) - 1;

  localparam logic [CFG_W-1:0] ROW_COUNT_RST = 7'd64;
  localparam logic [CFG_W-1:0] COL_COUNT_RST = 7'd64;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic {
    REG_ROW_COUNT = 1'b0,
    REG_COL_COUNT = 1'b1
  } reg_e;

  // Linear cell address of a grid coordinate.
  function automatic logic [ADDR_W-1:0] cell_addr(logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
    return ADDR_W'(row) * ADDR_W'(MAX_COLS) + ADDR_W'(col);
  endfunction

  // Clamps an internal distance to the result field.
  function automatic logic [OUT_W-1:0] sat_dist(logic [DIST_W-1:0] d);
    logic [DIST_EXT_W-1:0] e;
    e = {{(DIST_EXT_W - DIST_W){1'b0}}, d};
    if (e > DIST_EXT_W'(DIST_SAT)) begin
      return OUT_W'(DIST_SAT);
    end
    return e[OUT_W-1:0];
  endfunction

endpackage

@@ design/ngd_ram.sv @@
`timescale 1ns / 1ps

module ngd_ram #(
  parameter int Width = 1,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/nearest_one_grid_distance.sv @@
`timescale 1ns / 1ps

// Channel    | Direction | Handshake                          | Payload
// -----------+-----------+------------------------------------+------------------------------------
// config     | in / out  | psel, penable, pwrite, pready      | paddr, pwdata, prdata
// command    | in        | start accepted when busy is low    | opcode_i, row_i, col_i, cell_value_i
// result     | out       | done_o, one cycle, no back-pressure | distance_o, not_found_o
//
// A cell write completes in the cycle it is accepted; busy stays low.
// A query inside the active area scans rows*cols cells, one per cycle, then passes a
// drain state before its result shows; a query outside the area answers in the next
// cycle. After reset the block clears all MAX_ROWS*MAX_COLS cells, one per cycle,
// with busy high; configuration writes are taken meanwhile.
// The receiver cannot stall: each result is valid for exactly one cycle.

module nearest_one_grid_distance (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ngd_pkg::PADDR_W-1:0]   paddr,
  input  logic [ngd_pkg::PDATA_W-1:0]   pwdata,
  output logic [ngd_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          start,
  output logic                          busy,
  input  logic                          opcode_i,
  input  logic [ngd_pkg::FIELD_W-1:0]   row_i,
  input  logic [ngd_pkg::FIELD_W-1:0]   col_i,
  input  logic                          cell_value_i,
  output logic [ngd_pkg::OUT_W-1:0]     distance_o,
  output logic                          not_found_o,
  output logic                          done_o
);

  import ngd_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_e;

  state_e              state_q, state_d;
  logic [CFG_W-1:0]    row_count_q, col_count_q;
  logic [ROW_W-1:0]    srow_q, srow_d;
  logic [COL_W-1:0]    scol_q, scol_d;
  logic [ROW_W-1:0]    qrow_q, qrow_d;
  logic [COL_W-1:0]    qcol_q, qcol_d;
  logic                p_vld_q, p_vld_d;
  logic [ROW_W-1:0]    p_row_q;
  logic [COL_W-1:0]    p_col_q;
  logic [DIST_W-1:0]   best_q, best_d;
  logic                found_q, found_d;
  logic                done_q, done_d;
  logic [OUT_W-1:0]    dist_q, dist_d;
  logic                nf_q, nf_d;

  logic                cfg_we;
  logic [CMP_W-1:0]    row_cnt_ext, col_cnt_ext;
  logic [CMP_W-1:0]    rows_eff, cols_eff;
  logic [CMP_W-1:0]    row_ext, col_ext;
  logic                in_area;
  logic                accept;
  logic                row_last, col_last;
  logic [ROW_W-1:0]    diff_row;
  logic [COL_W-1:0]    diff_col;
  logic [DIST_W-1:0]   cur_dist;
  logic                hit;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic                ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic                ram_rdata;

  // Configuration port: zero-wait, so pready is tied high. A write lands on the
  // register selected by the word address bit.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_comb begin
    unique case (reg_e'(paddr[2]))
      REG_ROW_COUNT: prdata = {{(PDATA_W - CFG_W){1'b0}}, row_count_q};
      REG_COL_COUNT: prdata = {{(PDATA_W - CFG_W){1'b0}}, col_count_q};
      default:       prdata = '0;
    endcase
  end

  // Effective grid size: a count of zero acts as one, and a count beyond the
  // storage acts as the storage size.
  assign row_cnt_ext = {{(CMP_W - CFG_W){1'b0}}, row_count_q};
  assign col_cnt_ext = {{(CMP_W - CFG_W){1'b0}}, col_count_q};

  always_comb begin
    if (row_cnt_ext == '0) begin
      rows_eff = CMP_W'(1);
    end else if (row_cnt_ext > CMP_W'(MAX_ROWS)) begin
      rows_eff = CMP_W'(MAX_ROWS);
    end else begin
      rows_eff = row_cnt_ext;
    end
    if (col_cnt_ext == '0) begin
      cols_eff = CMP_W'(1);
    end else if (col_cnt_ext > CMP_W'(MAX_COLS)) begin
      cols_eff = CMP_W'(MAX_COLS);
    end else begin
      cols_eff = col_cnt_ext;
    end
  end

  assign row_ext = {{(CMP_W - FIELD_W){1'b0}}, row_i};
  assign col_ext = {{(CMP_W - FIELD_W){1'b0}}, col_i};
  assign in_area = (row_ext < rows_eff) && (col_ext < cols_eff);

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  // Scan position compared against the last active row and column.
  assign row_last = ({{(CMP_W - ROW_W){1'b0}}, srow_q} == (rows_eff - CMP_W'(1)));
  assign col_last = ({{(CMP_W - COL_W){1'b0}}, scol_q} == (cols_eff - CMP_W'(1)));

  // The shared distance unit: Manhattan distance between the cell whose bit has
  // just come out of the RAM and the queried cell.
  assign diff_row = (p_row_q >= qrow_q) ? (p_row_q - qrow_q) : (qrow_q - p_row_q);
  assign diff_col = (p_col_q >= qcol_q) ? (p_col_q - qcol_q) : (qcol_q - p_col_q);
  assign cur_dist = DIST_W'(diff_row) + DIST_W'(diff_col);
  assign hit      = p_vld_q && ram_rdata;

  assign ram_raddr = cell_addr(srow_q, scol_q);

  always_comb begin
    state_d   = state_q;
    srow_d    = srow_q;
    scol_d    = scol_q;
    qrow_d    = qrow_q;
    qcol_d    = qcol_q;
    p_vld_d   = 1'b0;
    done_d    = 1'b0;
    dist_d    = dist_q;
    nf_d      = nf_q;
    ram_we    = 1'b0;
    ram_waddr = cell_addr(row_ext[ROW_W-1:0], col_ext[COL_W-1:0]);
    ram_wdata = cell_value_i;

    // Running minimum over the set cells seen so far.
    best_d  = best_q;
    found_d = found_q || hit;
    if (hit && (!found_q || (cur_dist < best_q))) begin
      best_d = cur_dist;
    end

    unique case (state_q)
      ST_CLEAR: begin
        // Clearing pass over the whole storage, one cell per cycle.
        ram_we    = 1'b1;
        ram_waddr = cell_addr(srow_q, scol_q);
        ram_wdata = 1'b0;
        if (scol_q == COL_W'(MAX_COLS - 1)) begin
          scol_d = '0;
          if (srow_q == ROW_W'(MAX_ROWS - 1)) begin
            srow_d  = '0;
            state_d = ST_IDLE;
          end else begin
            srow_d = srow_q + ROW_W'(1);
          end
        end else begin
          scol_d = scol_q + COL_W'(1);
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (opcode_i == OP_WRITE) begin
            // Writes outside the active area are dropped.
            ram_we = in_area;
          end else if (in_area) begin
            qrow_d  = row_ext[ROW_W-1:0];
            qcol_d  = col_ext[COL_W-1:0];
            srow_d  = '0;
            scol_d  = '0;
            found_d = 1'b0;
            best_d  = '0;
            state_d = ST_SCAN;
          end else begin
            done_d = 1'b1;
            dist_d = '0;
            nf_d   = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        // Issue one read per cycle over the active rectangle, row by row.
        p_vld_d = 1'b1;
        if (col_last) begin
          scol_d = '0;
          if (row_last) begin
            state_d = ST_DRAIN;
          end else begin
            srow_d = srow_q + ROW_W'(1);
          end
        end else begin
          scol_d = scol_q + COL_W'(1);
        end
      end
      ST_DRAIN: begin
        // The last cell is folded in this cycle; the result register loads it.
        done_d  = 1'b1;
        nf_d    = !found_d;
        dist_d  = found_d ? sat_dist(best_d) : '0;
        srow_d  = '0;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      row_count_q <= ROW_COUNT_RST;
      col_count_q <= COL_COUNT_RST;
      srow_q      <= '0;
      scol_q      <= '0;
      p_vld_q     <= 1'b0;
      found_q     <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      srow_q  <= srow_d;
      scol_q  <= scol_d;
      p_vld_q <= p_vld_d;
      found_q <= found_d;
      done_q  <= done_d;
      if (cfg_we) begin
        unique case (reg_e'(paddr[2]))
          REG_ROW_COUNT: row_count_q <= pwdata[CFG_W-1:0];
          REG_COL_COUNT: col_count_q <= pwdata[CFG_W-1:0];
          default:       row_count_q <= row_count_q;
        endcase
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    qrow_q  <= qrow_d;
    qcol_q  <= qcol_d;
    p_row_q <= srow_q;
    p_col_q <= scol_q;
    best_q  <= best_d;
    dist_q  <= dist_d;
    nf_q    <= nf_d;
  end

  ngd_ram #(
    .Width (1),
    .Depth (CELLS)
  ) u_grid_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign done_o      = done_q;
  assign distance_o  = dist_q;
  assign not_found_o = nf_q;

`ifndef SYNTHESIS
  // A not-found result always reports a zero distance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(not_found_o && (distance_o != '0)))
    else $error("not_found result with nonzero distance");

  // An accepted query inside the active area starts a scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (opcode_i == OP_QUERY) && in_area) |=> busy)
    else $error("accepted query did not start a scan");

  // A cell write never produces a result transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (opcode_i == OP_WRITE)) |=> !done_o)
    else $error("cell write produced a result");
`endif

endmodule
